### src/soc_pkg.sv
// ----------------------------------------------------------------------------
// soc_pkg: shared types and constants of the substring occurrence counter
// Payload structs, configuration register codes, cell control and the
// pattern byte lookup used by the cell chain.
// ----------------------------------------------------------------------------
package soc_pkg;

  localparam int MaxPattern = 32;
  localparam int MaxCount   = 512;
  localparam int IdxW       = $clog2(MaxPattern);
  localparam int LenW       = 6;
  localparam int CountW     = 10;
  localparam int NumPatRegs = 4;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int BytesPerReg = CfgDataW / 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength = 3'd0,
    CfgPatternBytes0 = 3'd1,
    CfgPatternBytes1 = 3'd2,
    CfgPatternBytes2 = 3'd3,
    CfgPatternBytes3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic              match_ends_here;
    logic [CountW-1:0] occurrence_count;
    logic              text_done;
  } out_beat_t;

  // shift: beat taken and text goes on, clear: beat taken and text ends
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef logic [NumPatRegs-1:0][CfgDataW-1:0] pattern_regs_t;

  function automatic logic [7:0] pattern_byte(input pattern_regs_t regs,
                                              input logic [IdxW-1:0] idx);
    logic [1:0] reg_sel;
    logic [2:0] byte_sel;
    reg_sel  = idx[IdxW-1:3];
    byte_sel = idx[2:0];
    return regs[reg_sel][8*byte_sel +: 8];
  endfunction

endpackage

### src/substring_occurrence_counter_unit.sv
// ----------------------------------------------------------------------------
// substring_occurrence_counter_unit: overlapping pattern occurrence counter
// Counts every place where a pattern of 1 to 32 bytes ends in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: one text byte per beat plus an end-of-text flag
//   output channel: one beat per input beat with the match flag, the running
//   total (saturating at 512) and an echo of the end-of-text flag
//   config port: write enable, register index and 64-bit data; register 0 is
//   the pattern length, registers 1..4 hold pattern bytes 0..31, eight bytes
//   each, lowest byte first; write only while no beat is in flight
// Timing:
//   an accepted beat reaches the output in the next cycle; one byte is taken
//   every cycle unless stalled, the 31-cell history chain and the count
//   update finish in the accepting cycle; the output register is the only stage
//   while the output is stalled with a beat held, the input is stalled too
// Reset:
//   pattern length 1, pattern bytes zero, history empty, count zero
//   after a byte flagged end-of-text the history and count are cleared
// ----------------------------------------------------------------------------
module substring_occurrence_counter_unit
  import soc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int NumCells = MaxPattern - 1;

  logic [LenW-1:0] len_q;
  pattern_regs_t   pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgPatternLength: len_q    <= cfg_wdata_i[LenW-1:0];
        CfgPatternBytes0: pat_q[0] <= cfg_wdata_i;
        CfgPatternBytes1: pat_q[1] <= cfg_wdata_i;
        CfgPatternBytes2: pat_q[2] <= cfg_wdata_i;
        CfgPatternBytes3: pat_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // index of the last pattern byte in use, length clamped to 1..32
  logic [IdxW-1:0] last_idx;
  logic [LenW-1:0] len_m1;

  assign len_m1 = len_q - LenW'(1);

  always_comb begin
    if (len_q == '0) begin
      last_idx = '0;
    end else if (len_q > LenW'(MaxPattern)) begin
      last_idx = IdxW'(MaxPattern - 1);
    end else begin
      last_idx = len_m1[IdxW-1:0];
    end
  end

  logic       in_acc;
  cell_ctrl_t ctrl;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ctrl.shift = in_acc && !in_data_i.end_of_text;
  assign ctrl.clear = in_acc && in_data_i.end_of_text;

  logic [7:0]          chain_byte  [NumCells+1];
  logic                chain_valid [NumCells+1];
  logic [NumCells:0]   ok;

  // entry of the chain is the current byte
  assign chain_byte[0]  = in_data_i.text_byte;
  assign chain_valid[0] = 1'b1;
  assign ok[0] = (in_data_i.text_byte == pattern_byte(pat_q, last_idx));

  for (genvar k = 1; k <= NumCells; k++) begin : g_cell
    localparam logic [IdxW-1:0] CellIdx = IdxW'(k);
    logic [IdxW-1:0] pat_idx;
    assign pat_idx = last_idx - CellIdx;

    soc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .byte_i   (chain_byte[k-1]),
      .valid_i  (chain_valid[k-1]),
      .expect_i (pattern_byte(pat_q, pat_idx)),
      .in_use_i (CellIdx <= last_idx),
      .byte_o   (chain_byte[k]),
      .valid_o  (chain_valid[k]),
      .ok_o     (ok[k])
    );
  end

  logic              hit;
  logic [CountW-1:0] count_val;

  assign hit = &ok;

  soc_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .hit_i   (hit),
    .count_o (count_val)
  );

  logic      out_valid_q;
  out_beat_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q.match_ends_here  <= hit;
      out_data_q.occurrence_count <= count_val;
      out_data_q.text_done        <= in_data_i.end_of_text;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // every taken beat shows up at the output next cycle
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.match_ends_here) |-> (out_data_o.occurrence_count != '0))
    else $error("match flagged with zero count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.occurrence_count <= CountW'(MaxCount)))
    else $error("count above saturation limit");

  // first byte of a new text can hold at most one occurrence
  a_text_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_text) ##1 in_acc |-> (count_val <= CountW'(1)))
    else $error("count not cleared at end of text");

endmodule

### src/soc_cell.sv
// ----------------------------------------------------------------------------
// soc_cell: one history cell of the match chain
// Holds one earlier text byte and its valid flag, passes them on to the next
// cell on every shift beat and compares the byte to its aligned pattern byte.
// ----------------------------------------------------------------------------
module soc_cell
  import soc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic [7:0] expect_i,
  input  logic       in_use_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       ok_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  // cells past the pattern length do not take part
  assign ok_o    = !in_use_i || (valid_q && (byte_q == expect_i));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

### src/soc_count.sv
// ----------------------------------------------------------------------------
// soc_count: saturating occurrence counter
// Gives the total including the current beat and keeps it per text.
// ----------------------------------------------------------------------------
module soc_count
  import soc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              hit_i,
  output logic [CountW-1:0] count_o
);

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;

  always_comb begin
    count_d = count_q;
    if (hit_i && (count_q < CountW'(MaxCount))) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.shift) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule
